[hw/rtl/tfn_pkg.sv]
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared widths and types for the triangle face normal core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tfn_pkg;
  localparam int COORD_WIDTH      = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int OUT_W  = 16;
  localparam int EW     = COORD_WIDTH + 1;          // edge
  localparam int PW     = 2 * EW;                   // edge product
  localparam int CW     = PW + 1;                   // signed cross
  localparam int MW     = PW;                       // cross magnitude
  localparam int SW     = 2 * MW;                   // square
  localparam int LW     = SW + 2;                   // squared length
  localparam int F      = NORMAL_FRAC_BITS;
  localparam int QW     = F + 1;                    // quotient bits
  localparam int RW     = LW + 3 * F + 3;           // scaled residual
  localparam int YW     = LW + 2 * F + 1;           // scaled q * len2
  localparam int NCELLS = QW;

  typedef struct packed {
    logic [RW-1:0] r;
    logic [YW-1:0] y;
    logic [QW-1:0] q;
    logic          neg;
  } tfn_lane_t;

  typedef struct packed {
    tfn_lane_t [2:0] lane;
    logic [LW-1:0]   len2;
    logic            degen;
  } tfn_item_t;
endpackage
`default_nettype wire

[hw/rtl/triangle_face_normal_core.sv]
// ----------------------------------------------------------------------------
// triangle_face_normal_core
// Unit face normal of a triangle in signed Q1.14, flag on zero-length normal.
// ----------------------------------------------------------------------------
// Pipeline: 5 front stages, 15 quotient-bit cells and an output register.
// Throughput: one word per cycle; the whole pipe advances while the output
// register is empty or being taken.
// Reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module triangle_face_normal_core (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     in_valid,
  output logic                                          in_ready,
  input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   p0_x,
  input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   p0_y,
  input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   p0_z,
  input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   p1_x,
  input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   p1_y,
  input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   p1_z,
  input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   p2_x,
  input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   p2_y,
  input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   p2_z,
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic signed [tfn_pkg::OUT_W-1:0]              unit_x,
  output logic signed [tfn_pkg::OUT_W-1:0]              unit_y,
  output logic signed [tfn_pkg::OUT_W-1:0]              unit_z,
  output logic                                          degenerate
);
  localparam int N     = tfn_pkg::NCELLS;
  localparam int OUT_W = tfn_pkg::OUT_W;

  logic en;
  logic                 cv [N+1];
  tfn_pkg::tfn_item_t   ci [N+1];
  logic signed [OUT_W-1:0] u [3];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  tfn_front u_front (
    .clk, .rst, .en, .in_valid,
    .p0_x, .p0_y, .p0_z, .p1_x, .p1_y, .p1_z, .p2_x, .p2_y, .p2_z,
    .item_valid (cv[0]),
    .item       (ci[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_cell
    tfn_cell u_cell (
      .clk, .rst, .en,
      .in_valid  (cv[g]),
      .in_item   (ci[g]),
      .out_valid (cv[g+1]),
      .out_item  (ci[g+1])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u[i] = ci[N].lane[i].neg ? -OUT_W'(ci[N].lane[i].q) : OUT_W'(ci[N].lane[i].q);
      if (ci[N].degen) begin
        u[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_x     <= u[0];
      unit_y     <= u[1];
      unit_z     <= u[2];
      degenerate <= ci[N].degen;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/tfn_front.sv]
// ----------------------------------------------------------------------------
// tfn_front
// Edges, cross product, squares and squared length, five register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tfn_front (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     en,
  input  wire logic                                     in_valid,
  input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   p0_x,
  input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   p0_y,
  input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   p0_z,
  input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   p1_x,
  input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   p1_y,
  input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   p1_z,
  input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   p2_x,
  input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   p2_y,
  input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   p2_z,
  output logic                                          item_valid,
  output tfn_pkg::tfn_item_t                            item
);
  localparam int EW = tfn_pkg::EW;
  localparam int PW = tfn_pkg::PW;
  localparam int CW = tfn_pkg::CW;
  localparam int MW = tfn_pkg::MW;
  localparam int SW = tfn_pkg::SW;
  localparam int LW = tfn_pkg::LW;
  localparam int RW = tfn_pkg::RW;
  localparam int F  = tfn_pkg::F;

  logic [4:0] v;

  logic signed [EW-1:0] ax, ay, az, bx, by, bz;
  logic signed [PW-1:0] m0, m1, m2, m3, m4, m5;
  logic [MW-1:0] mag [3];
  logic [2:0] neg2;
  logic [SW-1:0] sq [3];
  logic [2:0] neg3;
  logic signed [CW-1:0] cr [3];
  logic signed [CW-1:0] ab [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:0], in_valid};
    end
  end

  always_comb begin
    cr[0] = CW'(m0) - CW'(m1);
    cr[1] = CW'(m2) - CW'(m3);
    cr[2] = CW'(m4) - CW'(m5);
    for (int i = 0; i < 3; i++) begin
      ab[i] = cr[i][CW-1] ? -cr[i] : cr[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax <= EW'(p1_x) - EW'(p0_x);
      ay <= EW'(p1_y) - EW'(p0_y);
      az <= EW'(p1_z) - EW'(p0_z);
      bx <= EW'(p2_x) - EW'(p0_x);
      by <= EW'(p2_y) - EW'(p0_y);
      bz <= EW'(p2_z) - EW'(p0_z);
      m0 <= ay * bz;
      m1 <= az * by;
      m2 <= az * bx;
      m3 <= ax * bz;
      m4 <= ax * by;
      m5 <= ay * bx;
      for (int i = 0; i < 3; i++) begin
        mag[i]  <= ab[i][MW-1:0];
        neg2[i] <= cr[i][CW-1];
        sq[i]   <= mag[i] * mag[i];
      end
      neg3 <= neg2;
      item.len2  <= LW'(sq[0]) + LW'(sq[1]) + LW'(sq[2]);
      item.degen <= (sq[0] == '0) && (sq[1] == '0) && (sq[2] == '0);
      for (int i = 0; i < 3; i++) begin
        item.lane[i].r   <= RW'(sq[i]) << (2 * F);
        item.lane[i].y   <= '0;
        item.lane[i].q   <= '0;
        item.lane[i].neg <= neg3[i];
      end
    end
  end

  assign item_valid = v[4];
endmodule
`default_nettype wire

[hw/rtl/tfn_cell.sv]
// ----------------------------------------------------------------------------
// tfn_cell
// One quotient bit for all three lanes: trial subtract, then rescale.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tfn_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire tfn_pkg::tfn_item_t  in_item,
  output logic                     out_valid,
  output tfn_pkg::tfn_item_t       out_item
);
  localparam int RW = tfn_pkg::RW;
  localparam int YW = tfn_pkg::YW;
  localparam int QW = tfn_pkg::QW;
  localparam int F  = tfn_pkg::F;

  tfn_pkg::tfn_item_t nxt;
  logic [RW-1:0] d [3];
  logic [2:0] take;

  always_comb begin
    nxt = in_item;
    for (int i = 0; i < 3; i++) begin
      d[i] = (RW'(in_item.lane[i].y) << (F + 1)) + (RW'(in_item.len2) << (2 * F));
      take[i] = d[i] <= in_item.lane[i].r;
      nxt.lane[i].r = (take[i] ? in_item.lane[i].r - d[i] : in_item.lane[i].r) << 2;
      nxt.lane[i].y = (take[i] ? in_item.lane[i].y + (YW'(in_item.len2) << F)
                               : in_item.lane[i].y) << 1;
      nxt.lane[i].q = {in_item.lane[i].q[QW-2:0], take[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= nxt;
    end
  end
endmodule
`default_nettype wire

[sim/triangle_face_normal_core_tb.sv]
// ----------------------------------------------------------------------------
// triangle_face_normal_core_tb
// Checks the unit face normal core against a bit-exact scoreboard model.
// Triangles are fed in random bursts while the output side stalls on its own
// pattern. Each returned word is matched in order against the exact truncated
// quotient c * 2^14 / |C|, with a flag for zero-length normals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef logic signed [tfn_pkg::COORD_WIDTH-1:0] coord_t;
typedef logic signed [tfn_pkg::OUT_W-1:0] comp_t;

typedef struct {
  comp_t ux;
  comp_t uy;
  comp_t uz;
  logic  degen;
} normal_t;

class normal_scoreboard;
  normal_t expected_q[$];
  int      errors = 0;

  function automatic comp_t unit_of(longint c, logic [127:0] len2);
    logic [127:0] mag, rhs, lhs, t;
    logic [15:0]  q;
    mag = (c < 0) ? -c : c;
    rhs = (mag * mag) << (2 * tfn_pkg::NORMAL_FRAC_BITS);
    q = '0;
    for (int b = tfn_pkg::NORMAL_FRAC_BITS; b >= 0; b--) begin
      t = q | (16'd1 << b);
      lhs = t * t * len2;
      if (lhs <= rhs) q = t[15:0];
    end
    return (c < 0) ? -q : q;
  endfunction

  function void note_triangle(coord_t p[9]);
    longint ax, ay, az, bx, by, bz, cx, cy, cz;
    logic [127:0] len2, mx, my, mz;
    normal_t n;
    ax = p[3] - p[0]; ay = p[4] - p[1]; az = p[5] - p[2];
    bx = p[6] - p[0]; by = p[7] - p[1]; bz = p[8] - p[2];
    cx = ay * bz - az * by;
    cy = az * bx - ax * bz;
    cz = ax * by - ay * bx;
    if (cx == 0 && cy == 0 && cz == 0) begin
      n = '{0, 0, 0, 1'b1};
    end else begin
      mx = (cx < 0) ? -cx : cx;
      my = (cy < 0) ? -cy : cy;
      mz = (cz < 0) ? -cz : cz;
      len2 = mx * mx + my * my + mz * mz;
      n.ux = unit_of(cx, len2);
      n.uy = unit_of(cy, len2);
      n.uz = unit_of(cz, len2);
      n.degen = 1'b0;
    end
    expected_q = {expected_q, n};
  endfunction

  function void check_normal(normal_t got);
    normal_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected word x=%0d y=%0d z=%0d d=%0d", $time,
               got.ux, got.uy, got.uz, got.degen);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (got.ux !== e.ux) begin
      $display("%0t: unit_x exp %0d act %0d", $time, e.ux, got.ux); errors++;
    end
    if (got.uy !== e.uy) begin
      $display("%0t: unit_y exp %0d act %0d", $time, e.uy, got.uy); errors++;
    end
    if (got.uz !== e.uz) begin
      $display("%0t: unit_z exp %0d act %0d", $time, e.uz, got.uz); errors++;
    end
    if (got.degen !== e.degen) begin
      $display("%0t: degenerate exp %0d act %0d", $time, e.degen, got.degen);
      errors++;
    end
  endfunction
endclass

module triangle_face_normal_core_tb;
  localparam int LATENCY = 21;
  localparam int IDLE_LIMIT = 5000;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   out_ready = 1'b0;
  logic   in_ready, out_valid, degenerate;
  coord_t p[9] = '{default: '0};
  comp_t  unit_x, unit_y, unit_z;
  int     idle_cycles = 0;

  normal_scoreboard sb = new();

  always #4 clk = ~clk;

  triangle_face_normal_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .p0_x(p[0]), .p0_y(p[1]), .p0_z(p[2]),
    .p1_x(p[3]), .p1_y(p[4]), .p1_z(p[5]),
    .p2_x(p[6]), .p2_y(p[7]), .p2_z(p[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
    .degenerate(degenerate)
  );

  // output side: stall pattern switches mode every so often
  int stall_mode = 0;
  int stall_left = 0;
  int stall_phase = 0;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 99) < 70);
      2: out_ready <= (stall_phase % 5 != 0);
      default: out_ready <= ($urandom_range(0, 99) < 15);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_normal('{unit_x, unit_y, unit_z, degenerate});
    if (!rst && ((in_valid && in_ready) || (out_valid && out_ready)))
      idle_cycles <= 0;
    else if (!rst)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("triangle_face_normal_core regression: fail");
      $finish;
    end
  end

  task automatic send_triangle(coord_t t[9]);
    @(negedge clk);
    in_valid = 1'b1;
    for (int i = 0; i < 9; i++) p[i] = t[i];
    do @(posedge clk); while (!in_ready);
    sb.note_triangle(t);
  endtask

  task automatic go_idle(int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    for (int i = 1; i < cycles; i++) @(negedge clk);
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic coord_t rand_coord(int shape);
    case (shape)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 63)) - 32);
      default: return ($urandom_range(0, 1)) ? coord_t'(16'sh7fff - $urandom_range(0, 3))
                                             : coord_t'(16'sh8000 + $urandom_range(0, 3));
    endcase
  endfunction

  task automatic random_triangle(output coord_t t[9]);
    int kind, shape, k;
    kind = $urandom_range(0, 99);
    shape = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 2);
    for (int i = 0; i < 9; i++) t[i] = rand_coord(shape);
    if (kind < 8) begin
      for (int i = 0; i < 3; i++) t[6 + i] = t[i];          // coincident vertex
    end else if (kind < 16) begin
      k = $signed($urandom_range(0, 6)) - 3;                  // collinear
      for (int i = 0; i < 3; i++) t[3 + i] = coord_t'(t[i] + (t[3 + i] - t[i]) / 4);
      for (int i = 0; i < 3; i++) t[6 + i] = coord_t'(t[i] + k * (t[3 + i] - t[i]));
    end else if (kind < 24) begin
      k = $urandom_range(0, 2);                               // parallel to a coordinate plane
      t[3 + k] = t[k];
      t[6 + k] = t[k];
    end
  endtask

  coord_t tri_in[9];
  int burst, gap;

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: zeros, extremes, axis normals, collinear, maximal edges
    tri_in = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                            send_triangle(tri_in);
    tri_in = '{0, 0, 0, 1, 0, 0, 0, 1, 0};                            send_triangle(tri_in);
    tri_in = '{0, 0, 0, 0, 1, 0, 1, 0, 0};                            send_triangle(tri_in);
    tri_in = '{0, 0, 0, 0, 1, 0, 0, 0, 1};                            send_triangle(tri_in);
    tri_in = '{0, 0, 0, 0, 0, 1, 1, 0, 0};                            send_triangle(tri_in);
    tri_in = '{5, 5, 5, 6, 6, 6, 9, 9, 9};                            send_triangle(tri_in);
    tri_in = '{-32768, -32768, -32768, 32767, -32768, -32768,
               -32768, 32767, -32768};                                send_triangle(tri_in);
    tri_in = '{32767, 32767, 32767, -32768, 32767, 32767,
               32767, -32768, 32767};                                 send_triangle(tri_in);
    tri_in = '{-32768, 32767, -32768, 32767, -32768, 32767,
               32767, 32767, -32768};                                 send_triangle(tri_in);
    tri_in = '{32767, -32768, 32767, -32768, 32767, -32768,
               -32768, -32768, 32767};                                send_triangle(tri_in);
    tri_in = '{-32768, -32768, -32768, -32768, -32768, -32768,
               -32768, -32768, -32768};                               send_triangle(tri_in);
    tri_in = '{1, 2, 3, 1, 2, 3, -4, 7, 100};                         send_triangle(tri_in);
    tri_in = '{0, 0, 0, 1, 1, 1, -1, 2, -1};                          send_triangle(tri_in);
    tri_in = '{0, 0, 0, 3, 0, 0, 0, 4, 0};                            send_triangle(tri_in);
    tri_in = '{0, 0, 0, 1, 1, 0, 1, 0, 1};                            send_triangle(tri_in);
    tri_in = '{0, 0, 0, 32767, 0, 0, 0, 32767, 1};                    send_triangle(tri_in);
    go_idle(1);

    for (int n = 0; n < 600; ) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int b = 0; b < burst && n < 600; b++, n++) begin
        random_triangle(tri_in);
        send_triangle(tri_in);
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) go_idle(gap);
      if (n >= 300 && n < 300 + burst) begin
        go_idle(1);
        drain();
      end
    end
    go_idle(1);

    drain();
    repeat (2 * LATENCY) @(posedge clk);
    if (sb.errors == 0)
      $display("triangle_face_normal_core regression: pass");
    else
      $display("triangle_face_normal_core regression: fail");
    $finish;
  end
endmodule
